[hw/rtl/wpe_pkg.sv]
// ----------------------------------------------------------------------------
// wpe_pkg
// Shared types, constants and the divide helper of the pixel bit encoder.
// ----------------------------------------------------------------------------
package wpe_pkg;

  localparam int PIXEL_BITS = 24;
  localparam int BIT_CNT_W  = $clog2(PIXEL_BITS + 1);

  localparam int CH_W     = 8;
  localparam int BRIGHT_W = 7;
  localparam int COUNT_W  = 10;
  localparam int PROD_W   = CH_W + BRIGHT_W;

  localparam logic [BRIGHT_W-1:0] BRIGHT_FULL = 7'd100;

  // divide by 100 as multiply by 5243 and shift by 19, exact below 43690
  localparam int             RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
  localparam int             RECIP_SHIFT = 19;
  localparam int             RPROD_W     = PROD_W + RECIP_W;

  // register indexes
  localparam logic [1:0] REG_BRIGHTNESS  = 2'd0;
  localparam logic [1:0] REG_DUTY_ONE    = 2'd1;
  localparam logic [1:0] REG_DUTY_ZERO   = 2'd2;
  localparam logic [1:0] REG_RESET_SLOTS = 2'd3;

  localparam logic [BRIGHT_W-1:0] BRIGHTNESS_RST  = 7'd30;
  localparam logic [CH_W-1:0]     DUTY_ONE_RST    = 8'd60;
  localparam logic [CH_W-1:0]     DUTY_ZERO_RST   = 8'd30;
  localparam logic [COUNT_W-1:0]  RESET_SLOTS_RST = 10'd50;

  typedef struct packed {
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] blue;
    logic            first_pixel;
    logic            last_pixel;
  } pixel_t;

  typedef struct packed {
    logic [CH_W-1:0]    duty;
    logic [COUNT_W-1:0] repeat_count;
    logic               last_of_run;
  } result_t;

  typedef struct packed {
    logic [BRIGHT_W-1:0] brightness;
    logic [CH_W-1:0]     duty_one;
    logic [CH_W-1:0]     duty_zero;
    logic [COUNT_W-1:0]  reset_slots;
  } cfg_t;

  // pending pixel handed from the scaler to the serializer
  typedef struct packed {
    logic                  valid;
    logic [PIXEL_BITS-1:0] word;
    logic                  first_pixel;
    logic                  last_pixel;
  } hold_t;

  function automatic logic [CH_W-1:0] div100(input logic [PROD_W-1:0] x);
    logic [RPROD_W-1:0] p;
    p = RPROD_W'(x) * RPROD_W'(RECIP_100);
    return p[RECIP_SHIFT +: CH_W];
  endfunction

endpackage

[hw/rtl/wpe_regs.sv]
// ----------------------------------------------------------------------------
// wpe_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module wpe_regs (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output wpe_pkg::cfg_t        cfg
);
  import wpe_pkg::*;

  logic                wr_en;
  logic [1:0]          idx;
  logic [BRIGHT_W-1:0] bright_wr;

  assign pready    = 1'b1;
  assign idx       = paddr[3:2];
  assign wr_en     = psel && penable && pwrite;
  assign bright_wr = (pwdata[BRIGHT_W-1:0] > BRIGHT_FULL) ? BRIGHT_FULL
                                                           : pwdata[BRIGHT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.brightness  <= BRIGHTNESS_RST;
      cfg.duty_one    <= DUTY_ONE_RST;
      cfg.duty_zero   <= DUTY_ZERO_RST;
      cfg.reset_slots <= RESET_SLOTS_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_BRIGHTNESS:  cfg.brightness  <= bright_wr;
        REG_DUTY_ONE:    cfg.duty_one    <= pwdata[CH_W-1:0];
        REG_DUTY_ZERO:   cfg.duty_zero   <= pwdata[CH_W-1:0];
        REG_RESET_SLOTS: cfg.reset_slots <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BRIGHTNESS:  prdata = 32'(cfg.brightness);
      REG_DUTY_ONE:    prdata = 32'(cfg.duty_one);
      REG_DUTY_ZERO:   prdata = 32'(cfg.duty_zero);
      REG_RESET_SLOTS: prdata = 32'(cfg.reset_slots);
      default:         prdata = 32'd0;
    endcase
  end

endmodule

[hw/rtl/wpe_scale.sv]
// ----------------------------------------------------------------------------
// wpe_scale
// Input holding register: brightness products, then divide by 100.
// ----------------------------------------------------------------------------
module wpe_scale (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  wpe_pkg::pixel_t               pixel,
  input  logic [wpe_pkg::BRIGHT_W-1:0]  brightness,
  input  logic                          load,
  output logic                          busy,
  output wpe_pkg::hold_t                hold
);
  import wpe_pkg::*;

  logic              valid;
  logic [PROD_W-1:0] prod_g;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_b;
  logic              first_pixel;
  logic              last_pixel;
  logic              accept;

  assign busy   = valid;
  assign accept = start && !valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (load) begin
      valid <= 1'b0;
    end
  end

  // channel times brightness, registered before the reciprocal multiply
  always_ff @(posedge clk) begin
    if (accept) begin
      prod_g      <= PROD_W'(pixel.green) * PROD_W'(brightness);
      prod_r      <= PROD_W'(pixel.red)   * PROD_W'(brightness);
      prod_b      <= PROD_W'(pixel.blue)  * PROD_W'(brightness);
      first_pixel <= pixel.first_pixel;
      last_pixel  <= pixel.last_pixel;
    end
  end

  always_comb begin
    hold.valid       = valid;
    hold.word        = PIXEL_BITS'({div100(prod_g), div100(prod_r), div100(prod_b)});
    hold.first_pixel = first_pixel;
    hold.last_pixel  = last_pixel;
  end

endmodule

[hw/rtl/wpe_serial.sv]
// ----------------------------------------------------------------------------
// wpe_serial
// Slot serializer: leading reset run, bit slots msb first, trailing reset run.
// ----------------------------------------------------------------------------
module wpe_serial (
  input  logic                 clk,
  input  logic                 rst,
  input  wpe_pkg::cfg_t        cfg,
  input  wpe_pkg::hold_t       hold,
  output logic                 load,
  output logic                 strobe,
  output wpe_pkg::result_t     result
);
  import wpe_pkg::*;

  logic [PIXEL_BITS-1:0] word;
  logic [PIXEL_BITS-1:0] word_next;
  logic [BIT_CNT_W-1:0]  bits_left;
  logic [BIT_CNT_W-1:0]  bits_left_next;
  logic                  lead;
  logic                  lead_next;
  logic                  trail;
  logic                  trail_next;
  logic                  active;
  logic                  finishing;
  logic                  rst_run;
  result_t               slot;

  assign active  = lead || trail || (bits_left != '0);
  assign rst_run = (cfg.reset_slots != '0);
  assign load    = hold.valid && (!active || finishing);

  always_comb begin
    word_next      = word;
    bits_left_next = bits_left;
    lead_next      = lead;
    trail_next     = trail;
    finishing      = 1'b0;
    slot.duty         = '0;
    slot.repeat_count = cfg.reset_slots;
    slot.last_of_run  = 1'b0;
    if (lead) begin
      lead_next = 1'b0;
    end else if (bits_left != '0) begin
      slot.duty         = word[PIXEL_BITS-1] ? cfg.duty_one : cfg.duty_zero;
      slot.repeat_count = COUNT_W'(1);
      slot.last_of_run  = (bits_left == BIT_CNT_W'(1)) && !trail;
      finishing         = slot.last_of_run;
      word_next         = word << 1;
      bits_left_next    = bits_left - BIT_CNT_W'(1);
    end else if (trail) begin
      slot.last_of_run = 1'b1;
      finishing        = 1'b1;
      trail_next       = 1'b0;
    end
    if (load) begin
      word_next      = hold.word;
      bits_left_next = BIT_CNT_W'(PIXEL_BITS);
      lead_next      = hold.first_pixel && rst_run;
      trail_next     = hold.last_pixel && rst_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_left <= '0;
      lead      <= 1'b0;
      trail     <= 1'b0;
      strobe    <= 1'b0;
    end else begin
      bits_left <= bits_left_next;
      lead      <= lead_next;
      trail     <= trail_next;
      strobe    <= active;
    end
  end

  always_ff @(posedge clk) begin
    word   <= word_next;
    result <= slot;
  end

endmodule

[hw/rtl/ws2812_pixel_bit_encoder.sv]
// ----------------------------------------------------------------------------
// ws2812_pixel_bit_encoder
// Turns pixels into WS2812 PWM duty slots, one slot transaction per cycle.
// ----------------------------------------------------------------------------
// A pixel transaction is taken when start is high and busy is low. Each pixel
// gives 24 bit-slot results, plus one reset-run result before it when it is
// marked first and one after it when it is marked last (reset runs vanish
// when reset_slots is 0). Results come out on result with strobe, one per
// cycle, and cannot be stalled: the receiver must take every strobed cycle.
// The output serializer sets the pace: consecutive pixels stream out with
// no gap as long as the next pixel is offered in time. A one-entry holding
// register in front of the serializer takes the next pixel while the current
// one is still going out, so busy is only high while that holding register
// is full. When the block is idle, the first slot of a pixel passes through
// the holding register, the serializer state and the registered result.
// Configuration writes belong in idle periods only.
// ----------------------------------------------------------------------------
module ws2812_pixel_bit_encoder (
  input  logic                 clk,
  input  logic                 rst,
  // pixel command side
  input  logic                 start,
  output logic                 busy,
  input  wpe_pkg::pixel_t      pixel,
  // slot result side
  output logic                 strobe,
  output wpe_pkg::result_t     result,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import wpe_pkg::*;

  cfg_t  cfg;    // live register values
  hold_t hold;   // scaled pixel waiting for the serializer
  logic  load;   // serializer takes the held pixel this cycle

  // register file, brightness saturates at 100 on write
  wpe_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // holding stage: channel times brightness, then divide by 100
  wpe_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .pixel      (pixel),
    .brightness (cfg.brightness),
    .load       (load),
    .busy       (busy),
    .hold       (hold)
  );

  // serializer with registered result output
  wpe_serial u_serial (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .hold   (hold),
    .load   (load),
    .strobe (strobe),
    .result (result)
  );

endmodule
